// ----- hdl/ops_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the odometry pose smoother.
// No dependencies; imported by every module of the block.
package ops_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int DEF_FRAC_BITS    = 16;

    // Factor format: unsigned Q1.16 over 17 bits, 65536 means 1.0
    localparam int          FACTOR_W     = 17;
    localparam logic [16:0] ONE_Q16      = 17'd65536;
    localparam logic [16:0] RESET_FACTOR = 17'd6554;

    // Register index on the configuration port
    localparam logic REG_FACTOR = 1'b0;

    // CORDIC gain 0.60725293 in Q30
    localparam longint GAIN_Q30 = 64'sd652032874;

    // Arctangent table, 32-bit binary angles (2^32 = 2*pi)
    localparam int ATAN_LEN = 24;
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Control word for the CORDIC unit
    typedef struct packed {
        logic start;
        logic vec;
    } t_cordic_ctl;

endpackage

// ----- hdl/ops_blend.sv -----
`timescale 1ns / 1ps
// Bit-serial blend: acc = old*65536 + f*(new-old), one factor bit per cycle.
// Depends on ops_pkg.
module ops_blend #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [16:0]           i_f,
    input  logic signed [W-1:0]   i_old,
    input  logic signed [W-1:0]   i_new,
    output logic                  o_done,
    output logic signed [W+17:0]  o_acc
);
    import ops_pkg::*;

    localparam int AW = W + 18;
    localparam int CW = $clog2(FACTOR_W);

    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] r_d;
    logic [16:0]          r_f;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic signed [W:0]    n_diff;

    assign n_diff = {i_new[W-1], i_new} - {i_old[W-1], i_old};

    // Control: count factor bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(FACTOR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift multiplicand left, factor right, add on set bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= {{2{i_old[W-1]}}, i_old, 16'h0};
            r_d   <= {{17{n_diff[W]}}, n_diff};
            r_f   <= i_f;
        end else if (r_busy) begin
            if (r_f[0]) begin
                r_acc <= r_acc + r_d;
            end
            r_d <= r_d <<< 1;
            r_f <= r_f >> 1;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

// ----- hdl/ops_cordic.sv -----
`timescale 1ns / 1ps
// Iterative CORDIC, one micro-rotation per cycle: sin/cos or atan2.
// Depends on ops_pkg.
module ops_cordic #(
    parameter int CORDIC_STEPS = ops_pkg::DEF_CORDIC_STEPS,
    parameter int FRAC_BITS    = ops_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ops_pkg::t_cordic_ctl          i_ctl,
    input  logic [15:0]                   i_ang,
    input  logic signed [FRAC_BITS+19:0]  i_x,
    input  logic signed [FRAC_BITS+19:0]  i_y,
    output logic                          o_done,
    output logic signed [FRAC_BITS+19:0]  o_sin,
    output logic signed [FRAC_BITS+19:0]  o_cos,
    output logic [15:0]                   o_ang
);
    import ops_pkg::*;

    localparam int     CW = FRAC_BITS + 20;
    localparam int     N  = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int     IW = $clog2(N);
    localparam longint X0 = (GAIN_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);

    logic signed [CW-1:0] r_x, r_y;
    logic signed [33:0]   r_z;
    logic [IW-1:0]        r_i;
    logic                 r_busy, r_done, r_flip, r_zero, r_vec;

    logic signed [CW-1:0] n_xs, n_ys;
    logic signed [33:0]   n_at;
    logic                 n_up;
    logic signed [15:0]   n_a;
    logic                 n_fl;
    logic [31:0]          n_z32;
    logic [31:0]          n_zr;

    assign n_a   = $signed(i_ang);
    assign n_fl  = (n_a > 16'sd16384) || (n_a < -16'sd16384);
    assign n_z32 = n_fl ? {~i_ang[15], i_ang[14:0], 16'h0} : {i_ang, 16'h0};

    assign n_xs = r_x >>> r_i;
    assign n_ys = r_y >>> r_i;
    assign n_at = {2'b00, ATAN_TAB[5'(r_i)]};
    // Rotate toward zero angle, or toward the x axis when vectoring
    assign n_up = r_vec ? (r_y <= 0) : (r_z >= 0);

    // Control: iteration counter and mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == IW'(N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load with quadrant correction, then iterate
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_vec <= i_ctl.vec;
            if (i_ctl.vec) begin
                r_flip <= 1'b0;
                r_zero <= (i_x == 0) && (i_y == 0);
                if (i_x < 0) begin
                    if (i_y >= 0) begin
                        r_x <= i_y;
                        r_y <= -i_x;
                        r_z <= 34'sd1073741824;
                    end else begin
                        r_x <= -i_y;
                        r_y <= i_x;
                        r_z <= -34'sd1073741824;
                    end
                end else begin
                    r_x <= i_x;
                    r_y <= i_y;
                    r_z <= '0;
                end
            end else begin
                r_flip <= n_fl;
                r_zero <= 1'b0;
                r_x    <= CW'(X0);
                r_y    <= '0;
                r_z    <= {{2{n_z32[31]}}, n_z32};
            end
        end else if (r_busy) begin
            if (n_up) begin
                r_x <= r_x - n_ys;
                r_y <= r_y + n_xs;
                r_z <= r_z - n_at;
            end else begin
                r_x <= r_x + n_ys;
                r_y <= r_y - n_xs;
                r_z <= r_z + n_at;
            end
        end
    end

    assign n_zr   = r_z[31:0] + 32'h0000_8000;
    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;
    assign o_ang  = r_zero ? 16'h0 : n_zr[31:16];

endmodule

// ----- hdl/odometry_pose_smoother.sv -----
`timescale 1ns / 1ps
// Odometry pose smoother: one smoothed word out for every sample word in. The first
// sample after reset is loaded into the output register in the cycle after it is taken,
// and the next sample can go in once that load is done. Each later sample passes
// through S_ROT_OLD, S_ROT_NEW, S_BLEND, S_VEC and S_OUT before the next one is taken;
// S_OUT waits while the previous word is still unread at the output. One shared CORDIC
// unit runs sin/cos of the old heading, sin/cos of the new heading, then atan2 of the
// blended sums, one iteration per cycle after loading its operands. A bit-serial blend
// of the heading sines and cosines sits between the last two.
// The five linear channels blend bit-serially alongside. A new sample is taken once the
// previous one is finished, even while its result still waits at the output.
// Depends on ops_pkg, ops_blend and ops_cordic.
module odometry_pose_smoother #(
    parameter int CORDIC_STEPS = ops_pkg::DEF_CORDIC_STEPS,
    parameter int FRAC_BITS    = ops_pkg::DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Sample input
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [15:0] i_heading,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_turn_rate,
    // Result output
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_avg_x,
    output logic signed [31:0] o_avg_y,
    output logic signed [15:0] o_avg_heading,
    output logic signed [31:0] o_avg_vel_x,
    output logic signed [31:0] o_avg_vel_y,
    output logic signed [31:0] o_avg_turn_rate
);
    import ops_pkg::*;

    localparam int CW = FRAC_BITS + 20;
    localparam int SW = FRAC_BITS + 2;

    typedef enum logic [2:0] {
        S_IDLE, S_ROT_OLD, S_ROT_NEW, S_BLEND, S_VEC, S_OUT
    } t_state;

    t_state r_state;
    logic [16:0] r_factor;
    logic        r_first;
    logic [31:0] r_sm_x, r_sm_y, r_sm_vx, r_sm_vy, r_sm_rate;
    logic [15:0] r_sm_heading, r_h_in;
    logic signed [SW-1:0] r_s1, r_c1;
    logic        r_out_valid;
    logic [31:0] r_o_x, r_o_y, r_o_vx, r_o_vy, r_o_rate;
    logic [15:0] r_o_h;

    logic        n_in_fire, n_cfg_wr, n_ema_go, n_hb_go, n_out_load;
    logic [16:0] n_f;
    t_cordic_ctl n_cctl;
    logic        c_done;
    logic signed [CW-1:0] c_sin, c_cos;
    logic [15:0] c_ang;
    logic signed [49:0] a_x, a_y, a_vx, a_vy, a_rate;
    logic signed [CW-1:0] a_s, a_c;
    logic        hb_done;

    function automatic logic [31:0] ema_round(input logic signed [49:0] a);
        logic [49:0] t;
        t = a + 50'sd32768;
        return t[47:16];
    endfunction

    // Configuration register
    assign n_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_FACTOR) ? {15'h0, r_factor} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= RESET_FACTOR;
        end else if (n_cfg_wr && paddr[2] == REG_FACTOR) begin
            r_factor <= pwdata[16:0];
        end
    end

    // Saturate the factor at 1.0
    assign n_f = (r_factor > ONE_Q16) ? ONE_Q16 : r_factor;

    assign o_in_ready = (r_state == S_IDLE);
    assign n_in_fire  = i_in_valid && o_in_ready;
    assign n_ema_go   = n_in_fire && !r_first;
    assign n_hb_go    = (r_state == S_ROT_NEW) && c_done;
    assign n_out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // Start the shared CORDIC at each phase
    always_comb begin
        n_cctl.start = n_ema_go || (r_state == S_ROT_OLD && c_done)
                       || (r_state == S_BLEND && hb_done);
        n_cctl.vec   = (r_state == S_BLEND);
    end

    ops_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (n_cctl),
        .i_ang  ((r_state == S_IDLE) ? r_sm_heading : r_h_in),
        .i_x    (a_c),
        .i_y    (a_s),
        .o_done (c_done),
        .o_sin  (c_sin),
        .o_cos  (c_cos),
        .o_ang  (c_ang)
    );

    // Heading sums of sines and cosines
    ops_blend #(.W(SW)) u_blend_s (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_hb_go), .i_f(n_f),
        .i_old(r_s1), .i_new(c_sin[SW-1:0]), .o_done(hb_done), .o_acc(a_s)
    );
    ops_blend #(.W(SW)) u_blend_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_hb_go), .i_f(n_f),
        .i_old(r_c1), .i_new(c_cos[SW-1:0]), .o_done(), .o_acc(a_c)
    );

    // Linear channels
    ops_blend #(.W(32)) u_blend_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_ema_go), .i_f(n_f),
        .i_old(r_sm_x), .i_new(i_pos_x), .o_done(), .o_acc(a_x)
    );
    ops_blend #(.W(32)) u_blend_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_ema_go), .i_f(n_f),
        .i_old(r_sm_y), .i_new(i_pos_y), .o_done(), .o_acc(a_y)
    );
    ops_blend #(.W(32)) u_blend_vx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_ema_go), .i_f(n_f),
        .i_old(r_sm_vx), .i_new(i_vel_x), .o_done(), .o_acc(a_vx)
    );
    ops_blend #(.W(32)) u_blend_vy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_ema_go), .i_f(n_f),
        .i_old(r_sm_vy), .i_new(i_vel_y), .o_done(), .o_acc(a_vy)
    );
    ops_blend #(.W(32)) u_blend_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_ema_go), .i_f(n_f),
        .i_old(r_sm_rate), .i_new(i_turn_rate), .o_done(), .o_acc(a_rate)
    );

    // Sequencer, smoothed state and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_first      <= 1'b1;
            r_out_valid  <= 1'b0;
            r_sm_x       <= '0;
            r_sm_y       <= '0;
            r_sm_heading <= '0;
            r_sm_vx      <= '0;
            r_sm_vy      <= '0;
            r_sm_rate    <= '0;
        end else begin
            // Raise valid on a new word, drop it once the word is taken
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_in_fire) begin
                        r_h_in <= i_heading;
                        if (r_first) begin
                            r_first      <= 1'b0;
                            r_sm_x       <= i_pos_x;
                            r_sm_y       <= i_pos_y;
                            r_sm_heading <= i_heading;
                            r_sm_vx      <= i_vel_x;
                            r_sm_vy      <= i_vel_y;
                            r_sm_rate    <= i_turn_rate;
                            r_state      <= S_OUT;
                        end else begin
                            r_state <= S_ROT_OLD;
                        end
                    end
                end
                S_ROT_OLD: begin
                    if (c_done) begin
                        r_s1    <= c_sin[SW-1:0];
                        r_c1    <= c_cos[SW-1:0];
                        r_state <= S_ROT_NEW;
                    end
                end
                S_ROT_NEW: begin
                    if (c_done) begin
                        r_state <= S_BLEND;
                    end
                end
                S_BLEND: begin
                    if (hb_done) begin
                        r_state <= S_VEC;
                    end
                end
                S_VEC: begin
                    if (c_done) begin
                        r_sm_heading <= c_ang;
                        r_sm_x       <= ema_round(a_x);
                        r_sm_y       <= ema_round(a_y);
                        r_sm_vx      <= ema_round(a_vx);
                        r_sm_vy      <= ema_round(a_vy);
                        r_sm_rate    <= ema_round(a_rate);
                        r_state      <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (n_out_load) begin
                        r_o_x       <= r_sm_x;
                        r_o_y       <= r_sm_y;
                        r_o_h       <= r_sm_heading;
                        r_o_vx      <= r_sm_vx;
                        r_o_vy      <= r_sm_vy;
                        r_o_rate    <= r_sm_rate;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_avg_x         = r_o_x;
    assign o_avg_y         = r_o_y;
    assign o_avg_heading   = r_o_h;
    assign o_avg_vel_x     = r_o_vx;
    assign o_avg_vel_y     = r_o_vy;
    assign o_avg_turn_rate = r_o_rate;

    // The first sample goes straight to the output stage
    a_first_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_in_fire && r_first |=> r_state == S_OUT && !r_first)
        else $error("first sample not loaded directly");

    // CORDIC finishes only while a CORDIC phase is waiting on it
    a_cordic_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_done |-> r_state == S_ROT_OLD || r_state == S_ROT_NEW || r_state == S_VEC)
        else $error("CORDIC done outside a CORDIC phase");

    // Heading sums finish only in the blend phase
    a_blend_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hb_done |-> r_state == S_BLEND)
        else $error("heading blend done outside blend phase");

endmodule

// ----- test/odometry_pose_smoother_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for odometry_pose_smoother: drives sample words with random
// handshake gaps, predicts smoothed pose and heading, and checks every result word.
// Depends on ops_pkg and the odometry_pose_smoother RTL.

typedef struct {
    logic [31:0] x, y, vx, vy, rate;
    logic [15:0] hdg;
} t_pose;

class pose_scoreboard;
    localparam int STEPS = (ops_pkg::DEF_CORDIC_STEPS > ops_pkg::ATAN_LEN) ?
        ops_pkg::ATAN_LEN : ops_pkg::DEF_CORDIC_STEPS;
    localparam int FB = ops_pkg::DEF_FRAC_BITS;

    t_pose       held;
    bit          first_pending;
    logic [16:0] factor;
    t_pose       pending_poses[$];
    int          errors;

    function new();
        held = '{default: '0};
        first_pending = 1;
        factor = ops_pkg::RESET_FACTOR;
        errors = 0;
    endfunction

    function automatic longint ashr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] blend(logic [31:0] old_v, logic [31:0] smp, longint f);
        longint acc;
        acc = (65536 - f) * longint'(signed'(old_v)) + f * longint'(signed'(smp)) + 32768;
        return acc[47:16];
    endfunction

    // Rotate a unit vector to the given binary angle
    function automatic void sin_cos(logic [15:0] ang, output longint s, output longint c);
        logic [31:0] z32;
        longint z, x, yv, nx;
        bit flip;
        z32 = {ang, 16'h0};
        z = longint'(signed'(z32));
        flip = 0;
        if (z > 64'sh40000000 || z < -64'sh40000000) begin
            z32 = z32 + 32'h80000000;
            z = longint'(signed'(z32));
            flip = 1;
        end
        x = (ops_pkg::GAIN_Q30 + (64'sd1 << (29 - FB))) >>> (30 - FB);
        yv = 0;
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                nx = x - ashr(yv, i);
                yv = yv + ashr(x, i);
                z -= longint'(ops_pkg::ATAN_TAB[i]);
            end else begin
                nx = x + ashr(yv, i);
                yv = yv - ashr(x, i);
                z += longint'(ops_pkg::ATAN_TAB[i]);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            yv = -yv;
        end
        s = yv;
        c = x;
    endfunction

    // Vectoring atan2, rounded to a 16-bit binary angle
    function automatic logic [15:0] atan2(longint yv, longint x);
        longint z, t, nx;
        logic [31:0] zw;
        if (x == 0 && yv == 0) return 16'h0;
        z = 0;
        if (x < 0) begin
            if (yv >= 0) begin
                t = x; x = yv; yv = -t; z = 64'sh40000000;
            end else begin
                t = x; x = -yv; yv = t; z = -64'sh40000000;
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            if (yv > 0) begin
                nx = x + ashr(yv, i);
                yv = yv - ashr(x, i);
                z += longint'(ops_pkg::ATAN_TAB[i]);
            end else begin
                nx = x - ashr(yv, i);
                yv = yv + ashr(x, i);
                z -= longint'(ops_pkg::ATAN_TAB[i]);
            end
            x = nx;
        end
        zw = z[31:0] + 32'h8000;
        return zw[31:16];
    endfunction

    // Advance the smoothed pose by one accepted sample word
    function void note_sample(t_pose smp);
        longint f, s1, c1, s2, c2;
        if (first_pending) begin
            held = smp;
            first_pending = 0;
        end else begin
            f = (factor > ops_pkg::ONE_Q16) ? 65536 : longint'(factor);
            held.x = blend(held.x, smp.x, f);
            held.y = blend(held.y, smp.y, f);
            sin_cos(held.hdg, s1, c1);
            sin_cos(smp.hdg, s2, c2);
            held.hdg = atan2((65536 - f) * s1 + f * s2, (65536 - f) * c1 + f * c2);
            held.vx = blend(held.vx, smp.vx, f);
            held.vy = blend(held.vy, smp.vy, f);
            held.rate = blend(held.rate, smp.rate, f);
        end
        pending_poses = {pending_poses, held};
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_result(t_pose got);
        t_pose e;
        if (pending_poses.size() == 0) begin
            $error("result word with nothing pending");
            errors++;
            return;
        end
        e = pending_poses.pop_front();
        check_field("avg_x", e.x, got.x);
        check_field("avg_y", e.y, got.y);
        check_field("avg_heading", {16'h0, e.hdg}, {16'h0, got.hdg});
        check_field("avg_vel_x", e.vx, got.vx);
        check_field("avg_vel_y", e.vy, got.vy);
        check_field("avg_turn_rate", e.rate, got.rate);
    endfunction
endclass

module odometry_pose_smoother_test;
    import ops_pkg::*;

    localparam int RANDOM_WORDS = 480;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic signed [31:0] i_pos_x = 0, i_pos_y = 0, i_vel_x = 0, i_vel_y = 0, i_turn_rate = 0;
    logic signed [15:0] i_heading = 0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic signed [31:0] o_avg_x, o_avg_y, o_avg_vel_x, o_avg_vel_y, o_avg_turn_rate;
    logic signed [15:0] o_avg_heading;

    pose_scoreboard pose_board = new();
    bit  calm_phase = 0;   // no idling near the end
    bit  hold_sink = 0;    // long receiver hold-off

    odometry_pose_smoother dut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    // Write the smoothing factor over the register port
    task automatic write_factor(logic [31:0] value);
        @(posedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= 3'(4 * REG_FACTOR); pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        pose_board.factor = value[16:0];
    endtask

    // Offer one sample word and hold it until accepted
    task automatic send_sample(logic [31:0] px, logic [31:0] py, logic [15:0] hd,
                               logic [31:0] vx, logic [31:0] vy, logic [31:0] rt);
        t_pose smp;
        if (!calm_phase && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_pos_x <= px; i_pos_y <= py; i_heading <= hd;
        i_vel_x <= vx; i_vel_y <= vy; i_turn_rate <= rt;
        do @(posedge i_clk); while (!o_in_ready);
        smp = '{x: px, y: py, hdg: hd, vx: vx, vy: vy, rate: rt};
        pose_board.note_sample(smp);
    endtask

    task automatic send_random();
        logic [31:0] v [5];
        for (int k = 0; k < 5; k++) begin
            case ($urandom_range(0, 3))
                0: v[k] = $urandom_range(0, 200000) - 100000;
                1: v[k] = $urandom() & 32'h8000_0001 | 32'h7fff_fffe & {32{$urandom_range(0, 1) == 1}};
                default: v[k] = $urandom();
            endcase
        end
        send_sample(v[0], v[1], 16'($urandom()), v[2], v[3], v[4]);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (pose_board.pending_poses.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else if (hold_sink) begin
            i_out_ready <= 0;
        end else begin
            i_out_ready <= calm_phase ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // Check each accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            pose_board.check_result('{x: o_avg_x, y: o_avg_y, hdg: o_avg_heading,
                vx: o_avg_vel_x, vy: o_avg_vel_y, rate: o_avg_turn_rate});
    end

    // Hold the receiver off for a long stretch once
    initial begin
        wait (hold_sink);
        repeat (400) @(posedge i_clk);
        hold_sink = 0;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // First sample loads directly, then extremes at reset factor
        send_sample(32'h7fffffff, 32'h80000000, 16'h7fff, 32'h0, 32'hffffffff, 32'h1);
        send_sample(32'h80000000, 32'h7fffffff, 16'h8000, 32'h7fffffff, 32'h80000000, 32'h0);
        send_sample(32'h0, 32'h0, 16'h0, 32'h0, 32'h0, 32'h0);
        send_sample(32'h10000, 32'hffff0000, 16'h4000, 32'h1, 32'hffffffff, 32'h12345);
        send_sample(32'h1, 32'h1, 16'hc000, 32'h1, 32'h1, 32'h1);
        drain();

        // Factor of one: each result takes the new sample outright
        write_factor(32'h10000);
        send_sample(32'h7fffffff, 32'h80000000, 16'h8000, 32'h1, 32'h2, 32'h3);
        send_sample(32'h0, 32'h0, 16'h0, 32'h0, 32'h0, 32'h0);
        drain();
        // Half factor with opposing headings
        write_factor(32'h8000);
        send_sample(32'h0, 32'h0, 16'h8000, 32'h0, 32'h0, 32'h0);
        send_sample(32'h0, 32'h0, 16'h4000, 32'h0, 32'h0, 32'h0);
        send_sample(32'h0, 32'h0, 16'hc000, 32'h0, 32'h0, 32'h0);
        drain();
        // Factor above one saturates
        write_factor(32'h1ffff);
        send_sample(32'h12345678, 32'h9abcdef0, 16'h1234, 32'h5, 32'h6, 32'h7);
        send_sample(32'h7fffffff, 32'h7fffffff, 16'h7fff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        drain();
        // Factor zero freezes the state
        write_factor(32'h0);
        send_sample(32'h80000000, 32'h80000000, 16'h8001, 32'h80000000, 32'h80000000, 32'h80000000);
        send_sample(32'h55555555, 32'haaaaaaaa, 16'h5555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
        drain();

        // Random phases over several factors; the receiver holds off in the first
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_factor(32'd6554);
                1: write_factor($urandom_range(0, 65536));
                2: write_factor(32'h1fffe);
                default: write_factor(32'd1);
            endcase
            if (ph == 0) hold_sink = 1;
            if (ph == 3) calm_phase = 1;
            for (int n = 0; n < RANDOM_WORDS / 4; n++) send_random();
            drain();
        end

        if (pose_board.errors == 0 && pose_board.pending_poses.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Timeout: all sample words plus stalls, taken several times over
    initial begin
        #(20ns * 400000);
        $display("Verification failed");
        $finish;
    end
endmodule
